/* design/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths and data types shared by the quaternion vector rotation datapath.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int DATA_W  = 16;             // input and output components
  localparam int PROD1_W = 2 * DATA_W;     // q times v product
  localparam int SUM1_W  = PROD1_W + 1;    // sum of three such products
  localparam int PROD2_W = SUM1_W + DATA_W; // p times q product
  localparam int SUM2_W  = PROD2_W + 1;    // sum of four such products
  localparam int LANES   = 3;

  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic signed [PROD1_W-1:0] prod1_t;
  typedef logic signed [SUM1_W-1:0]  sum1_t;
  typedef logic signed [PROD2_W-1:0] prod2_t;
  typedef logic signed [SUM2_W-1:0]  sum2_t;

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
    data_t w;
  } quat_t;

endpackage

/* design/quaternion_vector_rotate.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a 3-vector by a fixed-point quaternion: vector part of q*(v,0)*q'.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_stall   quat_x/y/z/w (Q1.FRAC_BITS), vec_x/y/z
//  out_     output     out_valid/out_stall rot_x/y/z, saturated
//
// A request can enter every cycle while the output is not stalled; the
// six register stages are product, sum, product, pair sum, rounding add and
// shift with saturation. Throughput is one request per clock unless stalled.
// Reset clears the stage valid bits only. A stall on the output freezes the
// whole pipe, and in_stall follows it in the same cycle while a result waits.
module quaternion_vector_rotate #(
  parameter int FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qvr_pkg::data_t in_quat_x,
  input  qvr_pkg::data_t in_quat_y,
  input  qvr_pkg::data_t in_quat_z,
  input  qvr_pkg::data_t in_quat_w,
  input  qvr_pkg::data_t in_vec_x,
  input  qvr_pkg::data_t in_vec_y,
  input  qvr_pkg::data_t in_vec_z,
  output logic          out_valid,
  input  logic          out_stall,
  output qvr_pkg::data_t out_rot_x,
  output qvr_pkg::data_t out_rot_y,
  output qvr_pkg::data_t out_rot_z,
  output logic          out_saturated
);
  import qvr_pkg::*;

  localparam int    STAGES = 6;
  localparam int    SHIFT  = 2 * FRAC_BITS;
  localparam sum2_t RND_C  = sum2_t'(1) <<< (SHIFT - 1);
  localparam sum2_t SAT_HI = sum2_t'(32767);
  localparam sum2_t SAT_LO = -sum2_t'(32768);
  localparam data_t OUT_HI = data_t'(32767);
  localparam data_t OUT_LO = data_t'(-32768);

  logic [STAGES-1:0] vld_r;
  logic              en;

  prod1_t prod1_r [12];
  quat_t  q1_r, q2_r;
  sum1_t  px_r, py_r, pz_r, pw_r;
  prod2_t prod2_r [12];
  sum2_t  pa_r [LANES];
  sum2_t  pb_r [LANES];
  sum2_t  acc_r [LANES];
  data_t  rot_r [LANES];
  logic   sat_r;

  data_t  rot_nxt [LANES];
  logic   sat_nxt;
  sum2_t  shifted;

  // The pipe moves as one; it holds only while a finished result is refused.
  assign en       = !vld_r[STAGES-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  // Stage 1: the twelve products of q and v.
  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r[0]  <= in_quat_w * in_vec_x;
      prod1_r[1]  <= in_quat_y * in_vec_z;
      prod1_r[2]  <= in_quat_z * in_vec_y;
      prod1_r[3]  <= in_quat_w * in_vec_y;
      prod1_r[4]  <= in_quat_z * in_vec_x;
      prod1_r[5]  <= in_quat_x * in_vec_z;
      prod1_r[6]  <= in_quat_w * in_vec_z;
      prod1_r[7]  <= in_quat_x * in_vec_y;
      prod1_r[8]  <= in_quat_y * in_vec_x;
      prod1_r[9]  <= in_quat_x * in_vec_x;
      prod1_r[10] <= in_quat_y * in_vec_y;
      prod1_r[11] <= in_quat_z * in_vec_z;
      q1_r        <= '{x: in_quat_x, y: in_quat_y, z: in_quat_z, w: in_quat_w};
    end
  end

  // Stage 2: p = q * (v, 0).
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= sum1_t'(prod1_r[0]) + sum1_t'(prod1_r[1]) - sum1_t'(prod1_r[2]);
      py_r <= sum1_t'(prod1_r[3]) + sum1_t'(prod1_r[4]) - sum1_t'(prod1_r[5]);
      pz_r <= sum1_t'(prod1_r[6]) + sum1_t'(prod1_r[7]) - sum1_t'(prod1_r[8]);
      pw_r <= -sum1_t'(prod1_r[9]) - sum1_t'(prod1_r[10]) - sum1_t'(prod1_r[11]);
      q2_r <= q1_r;
    end
  end

  // Stage 3: the twelve products of p and q.
  always_ff @(posedge clk) begin
    if (en) begin
      prod2_r[0]  <= px_r * q2_r.w;
      prod2_r[1]  <= pw_r * q2_r.x;
      prod2_r[2]  <= pz_r * q2_r.y;
      prod2_r[3]  <= py_r * q2_r.z;
      prod2_r[4]  <= py_r * q2_r.w;
      prod2_r[5]  <= pw_r * q2_r.y;
      prod2_r[6]  <= px_r * q2_r.z;
      prod2_r[7]  <= pz_r * q2_r.x;
      prod2_r[8]  <= pz_r * q2_r.w;
      prod2_r[9]  <= pw_r * q2_r.z;
      prod2_r[10] <= py_r * q2_r.x;
      prod2_r[11] <= px_r * q2_r.y;
    end
  end

  // Stages 4 and 5: vector part of p * conj(q), plus the half for rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        pa_r[i]  <= sum2_t'(prod2_r[4*i])   - sum2_t'(prod2_r[4*i+1]);
        pb_r[i]  <= sum2_t'(prod2_r[4*i+2]) - sum2_t'(prod2_r[4*i+3]);
        acc_r[i] <= pa_r[i] + pb_r[i] + RND_C;
      end
    end
  end

  // Stage 6: drop the fraction bits and clip to the output range.
  always_comb begin
    sat_nxt = 1'b0;
    shifted = '0;
    for (int i = 0; i < LANES; i++) begin
      shifted = acc_r[i] >>> SHIFT;
      if (shifted > SAT_HI) begin
        rot_nxt[i] = OUT_HI;
        sat_nxt    = 1'b1;
      end else if (shifted < SAT_LO) begin
        rot_nxt[i] = OUT_LO;
        sat_nxt    = 1'b1;
      end else begin
        rot_nxt[i] = shifted[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        rot_r[i] <= rot_nxt[i];
      end
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = vld_r[STAGES-1];
  assign out_rot_x     = rot_r[0];
  assign out_rot_y     = rot_r[1];
  assign out_rot_z     = rot_r[2];
  assign out_saturated = sat_r;

`ifndef NO_ASSERTIONS
  // A clipped result must show at least one component at a range limit.
  a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_rot_x == OUT_HI || out_rot_x == OUT_LO ||
       out_rot_y == OUT_HI || out_rot_y == OUT_LO ||
       out_rot_z == OUT_HI || out_rot_z == OUT_LO))
    else $error("saturated flag without a clipped component");

  // The input is held back only by a refused result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // A refused result stays in place.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_rot_x) &&
      $stable(out_rot_y) && $stable(out_rot_z) && $stable(out_saturated)))
    else $error("result changed while stalled");

  // Reset empties the pipe.
  a_reset : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

/* tb/quaternion_vector_rotate_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_tb
// Sends a short table of hand-picked rotations, then about two thousand random
// requests with bursts of idle and stall cycles on both channels. Each result
// is checked field by field against a typed table result or a bit-exact
// fixed-point rotation predictor.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_tb;
  import qvr_pkg::*;

  localparam int FRAC_BITS  = 14;
  localparam int RAND_ITEMS = 1950;
  localparam int TAIL_ITEMS = 150;
  localparam int DRAIN_CYC  = 12;

  typedef struct packed {
    quat_t q;
    data_t vx;
    data_t vy;
    data_t vz;
  } rot_req_t;

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
    logic  sat;
  } rot_res_t;

  typedef struct packed {
    rot_req_t req;
    logic     typed;
    rot_res_t res;
  } dir_row_t;

  // Rows with typed results are the cases that can be read off directly:
  // identity, zero quaternion, pure scaling by four, a half turn about z and
  // exact rounding ties. The rest go through the predictor.
  localparam int DIR_ROWS = 15;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{'{0, 0, 0, 16384}, 1000, -2000, 3000}, 1'b1, '{1000, -2000, 3000, 1'b0}},
    '{'{'{0, 0, 0, 16384}, 32767, -32768, 0}, 1'b1, '{32767, -32768, 0, 1'b0}},
    '{'{'{0, 0, 0, 0}, 32767, 32767, -32768}, 1'b1, '{0, 0, 0, 1'b0}},
    '{'{'{0, 0, 0, -32768}, 32767, -32768, 1}, 1'b1, '{32767, -32768, 4, 1'b1}},
    '{'{'{0, 0, 16384, 0}, -32768, 100, -32768}, 1'b1, '{32767, -100, -32768, 1'b1}},
    '{'{'{0, 0, 0, 128}, 8192, -8192, -24576}, 1'b1, '{1, 0, -1, 1'b0}},
    '{'{'{-32768, -32768, -32768, -32768}, -32768, -32768, -32768}, 1'b0, '{0, 0, 0, 1'b0}},
    '{'{'{32767, 32767, 32767, 32767}, 32767, 32767, 32767}, 1'b0, '{0, 0, 0, 1'b0}},
    '{'{'{11585, 0, 0, 11585}, 0, 16384, -300}, 1'b0, '{0, 0, 0, 1'b0}},
    '{'{'{16384, 16384, 16384, 16384}, 100, 200, 300}, 1'b0, '{0, 0, 0, 1'b0}},
    '{'{'{0, -32768, 0, 0}, 1, 2, 3}, 1'b0, '{0, 0, 0, 1'b0}},
    '{'{'{0, 0, -32768, 32767}, -1, -1, -1}, 1'b0, '{0, 0, 0, 1'b0}},
    '{'{'{-1, -1, -1, -1}, 32767, -32768, 32767}, 1'b0, '{0, 0, 0, 1'b0}},
    '{'{'{21845, -21846, 10922, -10923}, -21846, 21845, -1}, 1'b0, '{0, 0, 0, 1'b0}},
    '{'{'{8192, 8192, 8192, 8192}, -12345, 23456, -32768}, 1'b0, '{0, 0, 0, 1'b0}}
  };

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  data_t in_quat_x = '0;
  data_t in_quat_y = '0;
  data_t in_quat_z = '0;
  data_t in_quat_w = '0;
  data_t in_vec_x = '0;
  data_t in_vec_y = '0;
  data_t in_vec_z = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  data_t out_rot_x;
  data_t out_rot_y;
  data_t out_rot_z;
  logic  out_saturated;

  rot_res_t rotations_due [$];
  int       mismatch_count = 0;
  int       results_seen = 0;
  int       saturated_seen = 0;
  int       requests_sent = 0;
  bit       calm = 1'b0;
  int       stall_left = 0;

  quaternion_vector_rotate #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_quat_x    (in_quat_x),
    .in_quat_y    (in_quat_y),
    .in_quat_z    (in_quat_z),
    .in_quat_w    (in_quat_w),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rot_x    (out_rot_x),
    .out_rot_y    (out_rot_y),
    .out_rot_z    (out_rot_z),
    .out_saturated(out_saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Vector part of q * (v, 0) * conj(q), exact in 64 bits, one rounding at
  // the end with ties toward plus infinity, then saturation per lane.
  function automatic rot_res_t rotate_vector(rot_req_t r);
    longint x, y, z, w, vx, vy, vz;
    longint px, py, pz, pw, t;
    longint acc [3];
    data_t  lane [3];
    rot_res_t res;
    x  = r.q.x;
    y  = r.q.y;
    z  = r.q.z;
    w  = r.q.w;
    vx = r.vx;
    vy = r.vy;
    vz = r.vz;
    px = w * vx + y * vz - z * vy;
    py = w * vy + z * vx - x * vz;
    pz = w * vz + x * vy - y * vx;
    pw = -(x * vx) - y * vy - z * vz;
    acc[0] = px * w - pw * x - py * z + pz * y;
    acc[1] = py * w - pw * y - pz * x + px * z;
    acc[2] = pz * w - pw * z - px * y + py * x;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t = (acc[i] + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
      if (t > 32767) begin
        t = 32767;
        res.sat = 1'b1;
      end
      if (t < -32768) begin
        t = -32768;
        res.sat = 1'b1;
      end
      lane[i] = data_t'(t);
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    return res;
  endfunction

  function automatic data_t rand_sym(int m);
    return data_t'(int'($urandom_range(0, 2 * m)) - m);
  endfunction

  // A component near plus or minus one, with a random sign.
  function automatic data_t rand_major();
    return data_t'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(14000, 16384)));
  endfunction

  // Quaternions with random components up to about 0.707, some dominated by one
  // component, and a share of raw 16-bit values that mostly saturate.
  function automatic rot_req_t random_request();
    rot_req_t    r;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    r.vx = data_t'($urandom);
    r.vy = data_t'($urandom);
    r.vz = data_t'($urandom);
    case (mode)
      0, 1: begin
        r.q = quat_t'({$urandom, $urandom});
      end
      2, 3, 4, 5: begin
        r.q.x = rand_sym(11585);
        r.q.y = rand_sym(11585);
        r.q.z = rand_sym(11585);
        r.q.w = rand_sym(11585);
      end
      default: begin
        r.q.x = rand_sym(2048);
        r.q.y = rand_sym(2048);
        r.q.z = rand_sym(2048);
        r.q.w = rand_sym(2048);
        case ($urandom_range(0, 3))
          0: r.q.x = rand_major();
          1: r.q.y = rand_major();
          2: r.q.z = rand_major();
          default: r.q.w = rand_major();
        endcase
      end
    endcase
    // Small vectors keep the rounding step busy.
    if ($urandom_range(0, 7) == 0) begin
      r.vx = rand_sym(64);
      r.vy = rand_sym(64);
      r.vz = rand_sym(64);
    end
    return r;
  endfunction

  task automatic hold_off(int n);
    rot_req_t junk;
    repeat (n) begin
      @(negedge clk);
      junk      = random_request();
      in_valid  <= 1'b0;
      in_quat_x <= junk.q.x;
      in_quat_y <= junk.q.y;
      in_quat_z <= junk.q.z;
      in_quat_w <= junk.q.w;
      in_vec_x  <= junk.vx;
      in_vec_y  <= junk.vy;
      in_vec_z  <= junk.vz;
    end
  endtask

  task automatic send_rotation(rot_req_t r, rot_res_t due);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_quat_x <= r.q.x;
    in_quat_y <= r.q.y;
    in_quat_z <= r.q.z;
    in_quat_w <= r.q.w;
    in_vec_x  <= r.vx;
    in_vec_y  <= r.vy;
    in_vec_z  <= r.vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rotations_due.push_back(due);
    requests_sent++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Random stall bursts, none while the sender runs calm.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rot_res_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (out_saturated) saturated_seen++;
      if (rotations_due.size() == 0) begin
        report_mismatch("result with no request outstanding", out_rot_x, 0);
      end else begin
        want = rotations_due.pop_front();
        if (out_rot_x !== want.x) report_mismatch("rot_x", out_rot_x, want.x);
        if (out_rot_y !== want.y) report_mismatch("rot_y", out_rot_y, want.y);
        if (out_rot_z !== want.z) report_mismatch("rot_z", out_rot_z, want.z);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", out_saturated, want.sat);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d results still outstanding", rotations_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rot_req_t r;
    rot_res_t due;
    int       total;
    total = DIR_ROWS + RAND_ITEMS;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < total; i++) begin
      // Every third stretch of requests runs without gaps or stalls, and so
      // does the tail of the run.
      calm = ((i / 160) % 3 == 2) || (i >= total - TAIL_ITEMS);
      if (!calm && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 6));
      if (i < DIR_ROWS) begin
        r   = DIR_TAB[i].req;
        due = DIR_TAB[i].typed ? DIR_TAB[i].res : rotate_vector(r);
      end else begin
        r   = random_request();
        due = rotate_vector(r);
      end
      send_rotation(r, due);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (rotations_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Rotation requests sent: %0d (%0d from the directed table).",
             requests_sent, DIR_ROWS);
    $display("Results checked: %0d, of which %0d saturated; mismatches: %0d.",
             results_seen, saturated_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
